### rtl/dlwc_pkg.sv
// Package for the display list wireframe converter.
// Holds item types, parser codes and the vertex stride function.
// No dependencies.
`default_nettype none

package dlwc_pkg;

    localparam int unsigned MAX_ATTRIBUTES = 16;
    localparam int unsigned DESC_W         = 32;
    localparam int unsigned STRIDE_W       = 6;
    localparam int unsigned MAX_RESULTS    = 4;
    localparam int unsigned RES_CNT_W      = 3;

    localparam logic [7:0]  OP_MASK        = 8'hF8;
    localparam logic [7:0]  OP_HALT        = 8'h00;
    localparam logic [7:0]  OP_TRIANGLES   = 8'h90;
    localparam logic [7:0]  OP_STRIP       = 8'h98;
    localparam logic [7:0]  OP_FAN         = 8'hA0;
    localparam logic [15:0] MIN_VERTICES   = 16'd3;
    localparam logic [DESC_W-1:0] DESC_RESET = 32'd3;

    typedef enum logic [1:0]
    {
        PH_OPCODE,
        PH_COUNT_HI,
        PH_COUNT_LO,
        PH_VERTEX
    } phase_t;

    typedef enum logic [1:0]
    {
        KIND_LIST,
        KIND_STRIP,
        KIND_FAN,
        KIND_OTHER
    } kind_t;

    typedef enum logic [1:0]
    {
        CORNER_NONE,
        CORNER_ONE,
        CORNER_TWO,
        CORNER_STEP
    } corner_t;

    typedef struct packed
    {
        logic [7:0] list_byte;
        logic       list_end;
    } in_item_t;

    typedef struct packed
    {
        logic [15:0] vertex_index;
        logic        strip_begin;
        logic        strip_end;
    } out_item_t;

    function automatic logic [STRIDE_W-1:0] stride_bytes(input logic [DESC_W-1:0] desc);
        logic [STRIDE_W-2:0] n;
        n = '0;
        for (int i = 0; i < MAX_ATTRIBUTES; i++)
        begin
            if (desc[2*i +: 2] != 2'b00)
            begin
                n = n + (STRIDE_W-1)'(1);
            end
        end
        if (n == '0)
        begin
            n = (STRIDE_W-1)'(1);
        end
        return {n, 1'b0};
    endfunction

endpackage

`default_nettype wire

### rtl/display_list_wireframe_converter.sv
// Display list wireframe converter: top level.
// Parses a byte stream of primitives and emits line strip vertex indices.
// Depends on dlwc_pkg.
//
// Usage:
//   in channel: one display list byte per item (list_byte, list_end), taken on
//   in_valid high and in_stall low. out channel: one line strip vertex per item,
//   taken on out_valid high and out_stall low. cfg_write with cfg_data loads
//   the vertex descriptor; write it only while the block is idle.
//   An input byte is parsed in the cycle it is accepted and its results (0 to 4)
//   land in a four-entry result register; the first result is offered on the
//   next cycle, one result per cycle after that while out_stall is low.
//   A new byte is taken whenever the result register will be empty after this
//   cycle, so a byte that gives results holds the input until its last result
//   is taken, and the next byte can be accepted in the cycle that result leaves.
//   A stall on the out channel holds the current result and, once the result
//   register is not draining, stalls the in channel.
//   Reset clears the parser to wait for an opcode, empties the result register
//   and sets the descriptor to one attribute (stride of two bytes).
`default_nettype none

module display_list_wireframe_converter
    import dlwc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write,
    input  wire logic [DESC_W-1:0] cfg_data,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire in_item_t          in_item,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output out_item_t              out_item
);

    logic [STRIDE_W-1:0]  stride_reg;
    phase_t               phase_reg, phase_next;
    kind_t                kind_reg, kind_next;
    logic [15:0]          left_reg, left_next;
    logic [4:0]           bvi_reg, bvi_next;
    logic [7:0]           hi_reg, hi_next;
    logic [15:0]          anchor_reg, anchor_next;
    logic [15:0]          older_reg, older_next;
    logic [15:0]          newer_reg, newer_next;
    corner_t              corner_reg, corner_next;
    logic                 winding_reg, winding_next;
    logic                 halted_reg, halted_next;

    out_item_t            res_reg [MAX_RESULTS];
    out_item_t            res_next [MAX_RESULTS];
    logic [RES_CNT_W-1:0] cnt_reg, cnt_next;
    logic [RES_CNT_W-1:0] n_res;

    logic                 accept;
    logic                 pop;
    logic [7:0]           op;
    logic [15:0]          idx;
    logic [15:0]          cnt16;
    logic [4:0]           bvi_inc;

    assign out_valid = (cnt_reg != '0);
    assign out_item  = res_reg[0];
    assign pop       = out_valid && !out_stall;
    assign in_stall  = !((cnt_reg == '0) || ((cnt_reg == RES_CNT_W'(1)) && !out_stall));
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        phase_next   = phase_reg;
        kind_next    = kind_reg;
        left_next    = left_reg;
        bvi_next     = bvi_reg;
        hi_next      = hi_reg;
        anchor_next  = anchor_reg;
        older_next   = older_reg;
        newer_next   = newer_reg;
        corner_next  = corner_reg;
        winding_next = winding_reg;
        halted_next  = halted_reg;
        n_res        = '0;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            res_next[i] = '0;
        end

        op      = in_item.list_byte & OP_MASK;
        idx     = {hi_reg, in_item.list_byte};
        cnt16   = {left_reg[15:8], in_item.list_byte};
        bvi_inc = bvi_reg + 5'd1;

        if (!halted_reg)
        begin
            case (phase_reg)
                PH_OPCODE:
                begin
                    if (op == OP_HALT)
                    begin
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        if (op == OP_TRIANGLES)
                        begin
                            kind_next = KIND_LIST;
                        end
                        else if (op == OP_STRIP)
                        begin
                            kind_next = KIND_STRIP;
                        end
                        else if (op == OP_FAN)
                        begin
                            kind_next = KIND_FAN;
                        end
                        else
                        begin
                            kind_next = KIND_OTHER;
                        end
                        phase_next = PH_COUNT_HI;
                    end
                end
                PH_COUNT_HI:
                begin
                    left_next  = {in_item.list_byte, 8'h00};
                    phase_next = PH_COUNT_LO;
                end
                PH_COUNT_LO:
                begin
                    left_next = cnt16;
                    if (cnt16 < MIN_VERTICES)
                    begin
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        phase_next   = PH_VERTEX;
                        bvi_next     = '0;
                        corner_next  = CORNER_NONE;
                        winding_next = 1'b1;
                    end
                end
                PH_VERTEX:
                begin
                    if (bvi_reg == 5'd0)
                    begin
                        hi_next = in_item.list_byte;
                    end
                    else if (bvi_reg == 5'd1)
                    begin
                        case (corner_reg)
                            CORNER_NONE:
                            begin
                                anchor_next = idx;
                                corner_next = CORNER_ONE;
                            end
                            CORNER_ONE:
                            begin
                                older_next  = idx;
                                corner_next = CORNER_TWO;
                            end
                            CORNER_TWO:
                            begin
                                res_next[0] = '{anchor_reg, 1'b1, 1'b0};
                                res_next[1] = '{older_reg, 1'b0, 1'b0};
                                res_next[2] = '{idx, 1'b0, 1'b0};
                                res_next[3] = '{anchor_reg, 1'b0, 1'b1};
                                n_res       = RES_CNT_W'(4);
                                newer_next  = idx;
                                if (kind_reg == KIND_LIST)
                                begin
                                    corner_next = CORNER_NONE;
                                end
                                else if (kind_reg == KIND_OTHER)
                                begin
                                    halted_next = 1'b1;
                                end
                                else
                                begin
                                    corner_next = CORNER_STEP;
                                end
                            end
                            default:
                            begin
                                if (kind_reg == KIND_STRIP)
                                begin
                                    res_next[0] = '{winding_reg ? older_reg : newer_reg,
                                                    1'b1, 1'b0};
                                    res_next[2] = '{winding_reg ? newer_reg : older_reg,
                                                    1'b0, 1'b1};
                                    winding_next = !winding_reg;
                                end
                                else
                                begin
                                    res_next[0] = '{newer_reg, 1'b1, 1'b0};
                                    res_next[2] = '{anchor_reg, 1'b0, 1'b1};
                                end
                                res_next[1] = '{idx, 1'b0, 1'b0};
                                n_res       = RES_CNT_W'(3);
                                older_next  = newer_reg;
                                newer_next  = idx;
                            end
                        endcase
                    end
                    bvi_next = bvi_inc;
                    if (!halted_next && (({1'b0, bvi_inc} >= stride_reg) || (bvi_inc == 5'd0)))
                    begin
                        bvi_next  = '0;
                        left_next = left_reg - 16'd1;
                        if (left_reg == 16'd1)
                        begin
                            phase_next = PH_OPCODE;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_OPCODE;
                end
            endcase
        end

        if (in_item.list_end)
        begin
            phase_next  = PH_OPCODE;
            halted_next = 1'b0;
            bvi_next    = '0;
            left_next   = '0;
            corner_next = CORNER_NONE;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept)
        begin
            cnt_next = n_res;
        end
        else if (pop)
        begin
            cnt_next = cnt_reg - RES_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_reg  <= stride_bytes(DESC_RESET);
            phase_reg   <= PH_OPCODE;
            kind_reg    <= KIND_LIST;
            left_reg    <= '0;
            bvi_reg     <= '0;
            hi_reg      <= '0;
            anchor_reg  <= '0;
            older_reg   <= '0;
            newer_reg   <= '0;
            corner_reg  <= CORNER_NONE;
            winding_reg <= 1'b1;
            halted_reg  <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                stride_reg <= stride_bytes(cfg_data);
            end
            cnt_reg <= cnt_next;
            if (accept)
            begin
                phase_reg   <= phase_next;
                kind_reg    <= kind_next;
                left_reg    <= left_next;
                bvi_reg     <= bvi_next;
                hi_reg      <= hi_next;
                anchor_reg  <= anchor_next;
                older_reg   <= older_next;
                newer_reg   <= newer_next;
                corner_reg  <= corner_next;
                winding_reg <= winding_next;
                halted_reg  <= halted_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < MAX_RESULTS; i++)
            begin
                res_reg[i] <= res_next[i];
            end
        end
        else if (pop)
        begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                res_reg[i] <= res_reg[i+1];
            end
        end
    end

endmodule

`default_nettype wire
